FILE: hw/rtl/pcm_cvt_pkg.sv
// ----------------------------------------------------------------------------
// PCM converter package
// Mode codes and shared helpers for the sample format converter.
// ----------------------------------------------------------------------------
package pcm_cvt_pkg;

    typedef enum logic [3:0] {
        MODE_PASS     = 4'd0,
        MODE_U8       = 4'd1,
        MODE_U16      = 4'd2,
        MODE_SWAP16   = 4'd3,
        MODE_SWAP16_U = 4'd4,
        MODE_S24BE    = 4'd5,
        MODE_S24LE    = 4'd6,
        MODE_SWAP32   = 4'd7,
        MODE_FLOAT    = 4'd8,
        MODE_FLOAT_SW = 4'd9
    } t_mode;

    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX = 32'h8000_0000;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // Float front end result passed to the rounding stage.
    typedef struct packed {
        logic        special;   // NaN, infinity or too large
        logic [31:0] special_val;
        logic        neg;
        logic [31:0] q;         // truncated magnitude
        logic        half;
        logic        sticky;
    } t_flt;

endpackage

FILE: hw/rtl/pcm_cvt_align.sv
// ----------------------------------------------------------------------------
// PCM converter float align stage
// Decodes a single float and shifts its mantissa to the 2^31 scale.
// ----------------------------------------------------------------------------
module pcm_cvt_align (
    input  logic [31:0]        i_bits,
    output pcm_cvt_pkg::t_flt  o_flt
);
    logic [7:0]  w_exp;
    logic [23:0] w_man;
    logic [8:0]  w_eff;
    logic [63:0] w_wide;
    logic [5:0]  w_rsh;

    always_comb begin
        w_exp = i_bits[30:23];
        w_man = {(w_exp != 8'd0), i_bits[22:0]};
        w_eff = (w_exp == 8'd0) ? 9'd1 : {1'b0, w_exp};
        o_flt = '0;
        o_flt.neg = i_bits[31];
        w_rsh = '0;
        w_wide = '0;
        if (w_exp == 8'hFF) begin
            o_flt.special = 1'b1;
            o_flt.special_val = (i_bits[22:0] != 23'd0 || i_bits[31]) ?
                pcm_cvt_pkg::NEG_MAX : pcm_cvt_pkg::POS_MAX;
        end else if (w_eff > 9'd127) begin
            o_flt.special = 1'b1;
            o_flt.special_val = i_bits[31] ? pcm_cvt_pkg::NEG_MAX : pcm_cvt_pkg::POS_MAX;
        end else begin
            if (w_eff >= 9'd119) begin
                o_flt.q = {8'd0, w_man} << (w_eff - 9'd119);
            end else if (w_eff >= 9'd79) begin
                w_rsh = 6'(9'd119 - w_eff);
                w_wide = {8'd0, w_man, 32'd0} >> w_rsh;
                o_flt.q = w_wide[63:32];
                o_flt.half = w_wide[31];
                o_flt.sticky = (w_wide[30:0] != 31'd0);
            end
        end
    end
endmodule

FILE: hw/rtl/pcm_cvt_round.sv
// ----------------------------------------------------------------------------
// PCM converter float round stage
// Rounds to nearest even, saturates and negates.
// ----------------------------------------------------------------------------
module pcm_cvt_round (
    input  pcm_cvt_pkg::t_flt  i_flt,
    output logic [31:0]        o_val,
    output logic               o_sat
);
    logic [32:0] w_mag;
    logic        w_up;

    always_comb begin
        w_up  = i_flt.half && (i_flt.sticky || i_flt.q[0]);
        w_mag = {1'b0, i_flt.q} + {32'd0, w_up};
        o_sat = 1'b0;
        if (i_flt.special) begin
            o_sat = 1'b1;
            o_val = i_flt.special_val;
        end else if (!i_flt.neg) begin
            if (w_mag > 33'h0_7FFF_FFFF) begin
                o_sat = 1'b1;
                o_val = pcm_cvt_pkg::POS_MAX;
            end else begin
                o_val = w_mag[31:0];
            end
        end else if (w_mag > 33'h0_8000_0000) begin
            o_sat = 1'b1;
            o_val = pcm_cvt_pkg::NEG_MAX;
        end else begin
            o_val = 32'd0 - w_mag[31:0];
        end
    end
endmodule

FILE: hw/rtl/pcm_sample_format_converter.sv
// ----------------------------------------------------------------------------
// PCM sample format converter
// One request per cycle; busy stays 0.
// Stages: decode/align float, round/saturate, format and output register.
// Synchronous active-low reset clears valid bits and the mode register (pass).
// The receiver cannot stall; results show for one cycle on o_valid.
// ----------------------------------------------------------------------------
module pcm_sample_format_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,
    input  logic [31:0] i_raw_sample,
    output logic        o_valid,
    output logic [31:0] o_converted_sample,
    output logic        o_saturated
);
    logic [3:0]  r_mode;
    logic        r_v1, r_v2, r_v3;
    logic [31:0] r_raw1, r_raw2;
    logic [3:0]  r_m1, r_m2;
    pcm_cvt_pkg::t_flt r_flt;
    logic [31:0] r_fval;
    logic        r_fsat;
    logic [31:0] r_out;
    logic        r_sat;
    pcm_cvt_pkg::t_flt w_flt;
    logic [31:0] w_fval, n_out;
    logic        w_fsat, n_sat;

    assign busy = 1'b0;

    pcm_cvt_align u_align (.i_bits(i_raw_sample), .o_flt(w_flt));
    pcm_cvt_round u_round (.i_flt(r_flt), .o_val(w_fval), .o_sat(w_fsat));

    always_comb begin
        n_sat = 1'b0;
        unique case (r_m2)
            pcm_cvt_pkg::MODE_U8:       n_out = {24'd0, ~r_raw2[7], r_raw2[6:0]};
            pcm_cvt_pkg::MODE_U16:      n_out = {16'd0, ~r_raw2[15], r_raw2[14:0]};
            pcm_cvt_pkg::MODE_SWAP16:   n_out = {16'd0, r_raw2[7:0], r_raw2[15:8]};
            pcm_cvt_pkg::MODE_SWAP16_U: n_out = {16'd0, ~r_raw2[7], r_raw2[6:0], r_raw2[15:8]};
            pcm_cvt_pkg::MODE_S24BE:    n_out = {r_raw2[23:0], 8'd0};
            pcm_cvt_pkg::MODE_S24LE:    n_out = {r_raw2[7:0], r_raw2[15:8], r_raw2[23:16], 8'd0};
            pcm_cvt_pkg::MODE_SWAP32:   n_out = pcm_cvt_pkg::swap32(r_raw2);
            pcm_cvt_pkg::MODE_FLOAT: begin
                n_out = r_fval;
                n_sat = r_fsat;
            end
            pcm_cvt_pkg::MODE_FLOAT_SW: begin
                n_out = pcm_cvt_pkg::swap32(r_fval);
                n_sat = r_fsat;
            end
            default:                    n_out = r_raw2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 4'd0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            r_v1 <= start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_raw1 <= i_raw_sample;
        r_m1   <= r_mode;
        r_flt  <= w_flt;
        r_raw2 <= r_raw1;
        r_m2   <= r_m1;
        r_fval <= w_fval;
        r_fsat <= w_fsat;
        r_out  <= n_out;
        r_sat  <= n_sat;
    end

    assign o_valid = r_v3;
    assign o_converted_sample = r_out;
    assign o_saturated = r_sat;

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##3 o_valid) else $error("result lost");
    a_sat_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_m2 != pcm_cvt_pkg::MODE_FLOAT && r_m2 != pcm_cvt_pkg::MODE_FLOAT_SW)
        |=> !o_saturated) else $error("saturation outside float mode");
    a_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_m2 == pcm_cvt_pkg::MODE_FLOAT && r_raw2[30:23] == 8'hFF)
        |=> o_saturated) else $error("special float not flagged");
endmodule

FILE: sim/pcm_sample_format_converter_check.sv
// ----------------------------------------------------------------------------
// PCM converter result checker
// Watches requests, mode writes and results, predicts each converted
// sample in order and counts mismatches against the block's output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcm_sample_format_converter_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,
    input  logic [31:0] i_raw_sample,
    input  logic        i_valid,
    input  logic [31:0] i_converted_sample,
    input  logic        i_saturated,
    output int          o_mismatches,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0] sample;
        logic        sat;
    } t_pcm_out;

    logic [3:0] mode_copy;
    t_pcm_out   samples_due[$];

    // {saturated, value} for a float scaled by 2^31, nearest-even, clipped
    function automatic logic [32:0] float_to_pcm32(input logic [31:0] b);
        logic        neg;
        logic [7:0]  e;
        logic [63:0] m;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        int          shift;
        int          n;
        neg = b[31];
        e   = b[30:23];
        m   = {41'd0, b[22:0]};
        if (e == 8'hFF) begin
            return {1'b1, (m != 0 || neg) ? pcm_cvt_pkg::NEG_MAX : pcm_cvt_pkg::POS_MAX};
        end
        if (e == 0) begin
            shift = -118;
        end else begin
            m[23] = 1'b1;
            shift = int'(e) - 119;
        end
        if (shift > 8) begin
            mag = 64'h1_0000_0000;
        end else if (shift >= 0) begin
            mag = m << shift;
        end else begin
            n = -shift;
            if (n > 40) begin
                mag = 0;
            end else begin
                q    = m >> n;
                rem  = m & ((64'd1 << n) - 1);
                half = 64'd1 << (n - 1);
                if (rem > half || (rem == half && q[0]))
                    q = q + 1;
                mag = q;
            end
        end
        if (!neg) begin
            if (mag > 64'h7FFF_FFFF)
                return {1'b1, pcm_cvt_pkg::POS_MAX};
            return {1'b0, mag[31:0]};
        end
        if (mag > 64'h8000_0000)
            return {1'b1, pcm_cvt_pkg::NEG_MAX};
        return {1'b0, 32'd0 - mag[31:0]};
    endfunction

    function automatic t_pcm_out convert_sample(input logic [3:0] md, input logic [31:0] raw);
        t_pcm_out   r;
        logic [32:0] f;
        r.sat = 1'b0;
        case (md)
            pcm_cvt_pkg::MODE_U8:       r.sample = {24'd0, raw[7:0] ^ 8'h80};
            pcm_cvt_pkg::MODE_U16:      r.sample = {16'd0, raw[15:0] ^ 16'h8000};
            pcm_cvt_pkg::MODE_SWAP16:   r.sample = {16'd0, raw[7:0], raw[15:8]};
            pcm_cvt_pkg::MODE_SWAP16_U: r.sample = {16'd0, raw[7:0] ^ 8'h80, raw[15:8]};
            pcm_cvt_pkg::MODE_S24BE:    r.sample = {raw[23:0], 8'd0};
            pcm_cvt_pkg::MODE_S24LE:    r.sample = {raw[7:0], raw[15:8], raw[23:16], 8'd0};
            pcm_cvt_pkg::MODE_SWAP32:
                r.sample = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
            pcm_cvt_pkg::MODE_FLOAT: begin
                f        = float_to_pcm32(raw);
                r.sample = f[31:0];
                r.sat    = f[32];
            end
            pcm_cvt_pkg::MODE_FLOAT_SW: begin
                f        = float_to_pcm32(raw);
                r.sample = {f[7:0], f[15:8], f[23:16], f[31:24]};
                r.sat    = f[32];
            end
            default:       r.sample = raw;
        endcase
        return r;
    endfunction

    assign o_pending = samples_due.size();

    always @(posedge i_clk) begin
        t_pcm_out want;
        if (!i_rst_n) begin
            mode_copy = pcm_cvt_pkg::MODE_PASS;
            samples_due.delete();
            o_mismatches <= 0;
        end else begin
            if (i_valid) begin
                if (samples_due.size() == 0) begin
                    if (o_mismatches < 10)
                        $display("%0t: unexpected result %h sat %b", $time,
                                 i_converted_sample, i_saturated);
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    want = samples_due.pop_front();
                    if (want.sample !== i_converted_sample || want.sat !== i_saturated) begin
                        if (o_mismatches < 10)
                            $display("%0t: mode %0d expected %h sat %b, got %h sat %b",
                                     $time, mode_copy, want.sample, want.sat,
                                     i_converted_sample, i_saturated);
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
            if (i_start && !i_busy)
                samples_due.push_back(convert_sample(mode_copy, i_raw_sample));
            if (i_cfg_we)
                mode_copy = i_cfg_data;
        end
    end

endmodule

FILE: sim/pcm_sample_format_converter_test.sv
// ----------------------------------------------------------------------------
// PCM converter testbench
// Streams directed and random samples through every conversion mode under
// varying request gaps; a checker beside the block predicts each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcm_sample_format_converter_test;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [3:0]  i_cfg_data = '0;
    logic [31:0] i_raw_sample = '0;
    logic        o_valid;
    logic [31:0] o_converted_sample;
    logic        o_saturated;
    logic        busy_seen;
    int          mismatches;
    int          pending;
    int          idle_pct;
    int          sent;

    always #4 i_clk = ~i_clk;
    always @(negedge i_clk) busy_seen <= busy;

    pcm_sample_format_converter dut (
        .i_clk, .i_rst_n, .start, .busy, .i_cfg_we, .i_cfg_data,
        .i_raw_sample, .o_valid, .o_converted_sample, .o_saturated
    );

    pcm_sample_format_converter_check checker_i (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_cfg_we, .i_cfg_data,
        .i_raw_sample, .i_valid(o_valid), .i_converted_sample(o_converted_sample),
        .i_saturated(o_saturated), .o_mismatches(mismatches), .o_pending(pending)
    );

    task automatic send_sample(input logic [31:0] v);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_raw_sample <= v;
        @(posedge i_clk);
        while (busy_seen)
            @(posedge i_clk);
        sent++;
    endtask

    task automatic set_mode(input logic [3:0] md);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= md;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [31:0] pick_sample(input logic [3:0] md);
        logic [31:0] v;
        v = $urandom();
        if ((md == pcm_cvt_pkg::MODE_FLOAT || md == pcm_cvt_pkg::MODE_FLOAT_SW) &&
            $urandom_range(1))
            v[30:23] = 8'($urandom_range(160, 90));
        return v;
    endfunction

    initial begin
        logic [31:0] float_cases[$];
        logic [3:0]  md;
        int          first;
        float_cases = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                        32'h7FC0_0000, 32'hFFC0_0001, 32'h7F80_0000, 32'hFF80_0000,
                        32'h0000_0001, 32'h807F_FFFF, 32'h2F80_0000, 32'h3040_0000,
                        32'h3F00_0000, 32'h7F7F_FFFF, 32'hFFFF_FFFF, 32'h4F00_0000};
        idle_pct = 0;
        sent     = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0000);
        set_mode(pcm_cvt_pkg::MODE_FLOAT);
        foreach (float_cases[k]) send_sample(float_cases[k]);
        set_mode(pcm_cvt_pkg::MODE_FLOAT_SW);
        send_sample(32'hBF80_0000);
        send_sample(32'h3F7F_FFFF);

        for (int regime = 0; regime < 3; regime++) begin
            idle_pct = (regime == 0) ? 35 : (regime == 1) ? 68 : 0;
            first = $urandom_range(15);
            for (int j = 0; j < 16; j++) begin
                md = 4'(first + j);
                set_mode(md);
                repeat (31) send_sample(pick_sample(md));
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Sent %0d samples through all 16 mode codes, float edge cases included,",
                 sent);
        $display("with request gaps of 35, 68 and 0 percent.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
